// ===== rtl/lws_pkg.sv =====
package lws_pkg;

  // Default depth of the point store.
  localparam int unsigned LWS_PATH_DEPTH = 1024;

  // Field widths.
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned SQ_W      = 2 * COORD_W;
  localparam int unsigned DIST_W    = 50;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_POSE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GOAL_ERR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_DIST_SQ   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGOAL_DIST_SQ = 1'b1;

  // Configuration reset values.
  localparam logic [DIST_W-1:0] GOAL_DIST_SQ_RST   = 50'd65536;
  localparam logic [DIST_W-1:0] REGOAL_DIST_SQ_RST = 50'd16384;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } point_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    coord_t           pos_x;
    coord_t           pos_y;
    logic             path_first;
    logic             path_last;
  } req_t;

  typedef struct packed {
    logic   goal_valid;
    coord_t goal_x;
    coord_t goal_y;
    logic   odo_valid;
    coord_t odo_x;
    coord_t odo_y;
  } rsp_t;

  // Difference a - b, saturated to the coordinate range.
  function automatic coord_t sat_diff(coord_t a, coord_t b);
    logic [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (d[COORD_W] != d[COORD_W-1]) begin
      sat_diff = d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_diff = d[COORD_W-1:0];
    end
  endfunction

  // Square of the difference a - b, exact and always non-negative.
  function automatic logic [SQ_W-1:0] sq_diff(coord_t a, coord_t b);
    logic signed [COORD_W:0]   d;
    logic signed [SQ_W+1:0]    p;
    d = (COORD_W+1)'(a) - (COORD_W+1)'(b);
    p = d * d;
    sq_diff = p[SQ_W-1:0];
  endfunction

endpackage

// ===== rtl/lws_stream_if.sv =====
interface lws_stream_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ===== rtl/lookahead_waypoint_selector_unit.sv =====
// Channel   Role   Payload                                   Transaction
// req       sink   cmd, pos_x, pos_y, path_first, path_last  valid & ready
// rsp       source goal_valid/x/y, odo_valid/x/y             valid & ready
// cfg       write  cfg_we, cfg_index, cfg_data                cfg_we
//
// One item is processed at a time. A pose with a held path reads its goal
// point and checks its distance to it; a near pose or a path end starts a goal
// selection that scans the stored points through the registered memory read
// and squares. A goal error event is ignored when no path is held.
// The scan is set by the single read port of the point store. Reset is
// synchronous; the store needs no clearing.
// A result waiting in the output register does not block the next request.
module lookahead_waypoint_selector_unit
  import lws_pkg::*;
#(
  parameter int unsigned PATH_DEPTH = LWS_PATH_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  lws_stream_if.sink           req,
  lws_stream_if.source         rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data
);

  localparam int unsigned IW = $clog2(PATH_DEPTH);
  localparam int unsigned CW = $clog2(PATH_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(PATH_DEPTH);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_EXEC      = 4'd1;
  localparam logic [3:0] ST_CHECK     = 4'd2;
  localparam logic [3:0] ST_CHECK_CMP = 4'd3;
  localparam logic [3:0] ST_REF       = 4'd4;
  localparam logic [3:0] ST_REF_LOAD  = 4'd5;
  localparam logic [3:0] ST_SCAN      = 4'd6;
  localparam logic [3:0] ST_EMIT      = 4'd7;
  localparam logic [3:0] ST_EMIT_LOAD = 4'd8;
  localparam logic [3:0] ST_DONE      = 4'd9;

  // Control state.
  logic [3:0]        state;
  logic [CW-1:0]     point_count;
  logic [IW-1:0]     goal_index;
  logic              path_ok;
  coord_t            origin_x;
  coord_t            origin_y;
  logic              origin_set;
  logic [DIST_W-1:0] goal_dist_sq;
  logic [DIST_W-1:0] regoal_dist_sq;
  logic              v1;
  logic              v2;
  logic              out_valid;

  // Datapath registers.
  logic [CMD_W-1:0]  cmd_q;
  coord_t            px_q;
  coord_t            py_q;
  logic              first_q;
  logic              last_q;
  coord_t            ref_x;
  coord_t            ref_y;
  logic [IW-1:0]     iss;
  logic [IW-1:0]     idx1;
  logic [IW-1:0]     idx2;
  logic [SQ_W-1:0]   sq_x;
  logic [SQ_W-1:0]   sq_y;
  rsp_t              res;
  rsp_t              out_q;

  // Point store.
  point_t            mem [PATH_DEPTH];
  point_t            mem_q;
  logic              mem_we;
  logic [IW-1:0]     mem_wa;
  point_t            mem_wd;
  logic              mem_re;
  logic [IW-1:0]     mem_ra;

  logic [CW-1:0]     load_base;
  logic              load_room;
  logic [CW-1:0]     load_count;
  logic [IW-1:0]     slot_goal;
  logic [IW-1:0]     slot_zero;
  logic [IW-1:0]     slot_iss;
  logic [SQ_W:0]     dist_sum;
  logic              dist_far;
  logic              dist_near;
  logic              scan_more;
  logic              scan_hit;
  logic              scan_issue;
  logic              out_free;

  assign req.ready   = (state == ST_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_q;
  assign out_free    = !out_valid || rsp.ready;

  // Stored points are read newest first: logical index i sits at count-1-i.
  assign slot_goal = IW'(point_count - CW'(1) - CW'(goal_index));
  assign slot_zero = IW'(point_count - CW'(1));
  assign slot_iss  = IW'(point_count - CW'(1) - CW'(iss));

  // Where a loaded point goes, and the count after it.
  assign load_base  = first_q ? '0 : point_count;
  assign load_room  = (load_base < DEPTH_C);
  assign load_count = load_room ? (load_base + CW'(1)) : load_base;

  // Distance compare on the registered squares.
  assign dist_sum  = {1'b0, sq_x} + {1'b0, sq_y};
  assign dist_far  = (DIST_W'(dist_sum) > goal_dist_sq);
  assign dist_near = (DIST_W'(dist_sum) <= regoal_dist_sq);

  // Scan control: one read issued per cycle until a hit comes back or no stored point is left.
  assign scan_more  = ((CW'(iss) + CW'(1)) < point_count);
  assign scan_hit   = v2 && dist_far;
  assign scan_issue = (state == ST_SCAN) && !scan_hit && scan_more;

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = load_base[IW-1:0];
    mem_wd = '{y: py_q, x: px_q};
    mem_re = 1'b0;
    mem_ra = slot_goal;
    unique case (state)
      ST_EXEC: begin
        if (cmd_q == CMD_LOAD) begin
          mem_we = load_room;
        end else if (cmd_q == CMD_POSE) begin
          mem_re = 1'b1;
        end
      end
      ST_REF: begin
        mem_re = 1'b1;
        mem_ra = slot_zero;
      end
      ST_SCAN: begin
        mem_re = scan_issue;
        mem_ra = slot_iss;
      end
      ST_EMIT: begin
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Point store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      point_count    <= '0;
      goal_index     <= '0;
      path_ok        <= 1'b0;
      origin_x       <= '0;
      origin_y       <= '0;
      origin_set     <= 1'b0;
      goal_dist_sq   <= GOAL_DIST_SQ_RST;
      regoal_dist_sq <= REGOAL_DIST_SQ_RST;
      v1             <= 1'b0;
      v2             <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GOAL_DIST_SQ:   goal_dist_sq   <= cfg_data;
          CFG_REGOAL_DIST_SQ: regoal_dist_sq <= cfg_data;
          default: begin
          end
        endcase
      end

      // The output register fills from a finished item and empties on a result transaction.
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (cmd_q)
            CMD_POSE: begin
              if (!origin_set) begin
                origin_x   <= px_q;
                origin_y   <= py_q;
                origin_set <= 1'b1;
              end
              if (path_ok && (CW'(goal_index) < point_count)) begin
                state <= ST_CHECK;
              end else begin
                state <= ST_DONE;
              end
            end
            CMD_LOAD: begin
              point_count <= load_count;
              path_ok     <= last_q && (load_count > CW'(1));
              if (first_q || last_q) begin
                goal_index <= '0;
              end
              state <= (last_q && (load_count > CW'(1))) ? ST_REF : ST_DONE;
            end
            CMD_GOAL_ERR: begin
              if (path_ok && (point_count > CW'(1))) begin
                if (CW'(goal_index) < (point_count - CW'(1))) begin
                  goal_index <= goal_index + IW'(1);
                end else begin
                  goal_index <= goal_index - IW'(1);
                end
                state <= ST_EMIT;
              end else begin
                state <= ST_DONE;
              end
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_CHECK: begin
          state <= ST_CHECK_CMP;
        end
        ST_CHECK_CMP: begin
          state <= dist_near ? ST_SCAN : ST_DONE;
        end
        ST_REF: begin
          state <= ST_REF_LOAD;
        end
        ST_REF_LOAD: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_hit) begin
            goal_index <= idx2;
            v1         <= 1'b0;
            v2         <= 1'b0;
            state      <= ST_EMIT;
          end else if (!v1 && !v2 && !scan_more) begin
            goal_index <= IW'(point_count - CW'(1));
            state      <= ST_EMIT;
          end else begin
            v1 <= scan_issue;
            v2 <= v1;
          end
        end
        ST_EMIT: begin
          state <= ST_EMIT_LOAD;
        end
        ST_EMIT_LOAD: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: request capture, squares, scan indexes and the result.
  always_ff @(posedge clk) begin
    sq_x <= sq_diff(mem_q.x, ref_x);
    sq_y <= sq_diff(mem_q.y, ref_y);
    idx1 <= iss;
    idx2 <= idx1;
    if (scan_issue) begin
      iss <= iss + IW'(1);
    end

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          cmd_q   <= req.payload.cmd;
          px_q    <= req.payload.pos_x;
          py_q    <= req.payload.pos_y;
          first_q <= req.payload.path_first;
          last_q  <= req.payload.path_last;
        end
      end
      ST_EXEC: begin
        if (cmd_q == CMD_POSE) begin
          ref_x <= px_q;
          ref_y <= py_q;
        end
        if (cmd_q == CMD_POSE && origin_set) begin
          res <= '{goal_valid: 1'b0, goal_x: '0, goal_y: '0, odo_valid: 1'b1,
                   odo_x: sat_diff(px_q, origin_x), odo_y: sat_diff(py_q, origin_y)};
        end else begin
          res <= '0;
        end
      end
      ST_CHECK_CMP: begin
        iss <= goal_index;
      end
      ST_REF_LOAD: begin
        ref_x <= mem_q.x;
        ref_y <= mem_q.y;
        iss   <= IW'(1);
      end
      ST_EMIT_LOAD: begin
        res <= '{goal_valid: 1'b1, goal_x: sat_diff(mem_q.x, origin_x),
                 goal_y: sat_diff(mem_q.y, origin_y), odo_valid: res.odo_valid,
                 odo_x: res.odo_x, odo_y: res.odo_y};
      end
      ST_DONE: begin
        if (out_free) begin
          out_q <= res;
        end
      end
      default: begin
      end
    endcase
  end

  // A held path always has a goal inside it.
  a_goal_in_path: assert property (@(posedge clk) disable iff (rst)
    path_ok |-> ((CW'(goal_index) < point_count) && (point_count > CW'(1))))
    else $error("goal index outside the held path");

  // No scan read is in flight outside the scan.
  a_scan_drained: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SCAN) |-> (!v1 && !v2))
    else $error("scan pipeline not drained");

  // A finished result waits while the output register is still occupied.
  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !rsp.ready) |=> (state == ST_DONE))
    else $error("result dropped while output register busy");

endmodule
